// File: hw/rtl/cs3_pkg.sv
`timescale 1ns / 1ps

package cs3_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int STORE_DEPTH = 12;
    localparam int IDX_W       = 4;
    localparam int TERM_W      = 3;
    localparam int MAG_W       = DATA_WIDTH;
    // a triple product of magnitudes needs 3*MAG_W bits, sum of six adds 3 more, sign adds 1
    localparam int PROD_W      = 3 * MAG_W;
    localparam int DET_W       = PROD_W + 4;
    localparam int NUM_W       = DET_W + FRAC_BITS;
    localparam int QCNT_W      = $clog2(NUM_W + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TERM_LOAD,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_ACCUM,
        ST_DET_DONE,
        ST_DIV,
        ST_EMIT
    } cs3_state_t;

    typedef struct packed {
        logic       term_load;
        logic       mul1;
        logic       mul2;
        logic       mul3;
        logic       accum;
        logic       det_done;
        logic       div_start;
        logic       div_step;
        logic       emit;
        logic [2:0] term;
        logic [1:0] col;      // 0..2 replaced column, 3 for main determinant
    } cs3_cmd_t;

    typedef struct packed {
        logic det_zero;
        logic main_zero;
        logic div_done;
    } cs3_sts_t;

    localparam logic [1:0] COL_MAIN = 2'd3;

    // row-major positions for the six determinant terms
    function automatic logic [IDX_W-1:0] term_pos(input logic [2:0] t, input logic [1:0] k);
        logic [IDX_W-1:0] p;
        p = '0;
        case (t)
            3'd0: p = (k == 2'd0) ? 4'd0 : (k == 2'd1) ? 4'd4 : 4'd8;
            3'd1: p = (k == 2'd0) ? 4'd1 : (k == 2'd1) ? 4'd5 : 4'd6;
            3'd2: p = (k == 2'd0) ? 4'd3 : (k == 2'd1) ? 4'd7 : 4'd2;
            3'd3: p = (k == 2'd0) ? 4'd2 : (k == 2'd1) ? 4'd4 : 4'd6;
            3'd4: p = (k == 2'd0) ? 4'd0 : (k == 2'd1) ? 4'd5 : 4'd7;
            3'd5: p = (k == 2'd0) ? 4'd1 : (k == 2'd1) ? 4'd3 : 4'd8;
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

// File: hw/rtl/cs3_ctrl.sv
`timescale 1ns / 1ps

module cs3_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               out_free,
    input  cs3_pkg::cs3_sts_t  sts,
    output cs3_pkg::cs3_cmd_t  cmd,
    output logic               busy,
    output logic [1:0]         root_num
);

    cs3_pkg::cs3_state_t state_reg, state_next;
    logic [2:0] term_reg, term_next;
    logic [1:0] col_reg, col_next;
    logic [1:0] root_reg, root_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cs3_pkg::ST_IDLE;
            term_reg  <= '0;
            col_reg   <= cs3_pkg::COL_MAIN;
            root_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
            col_reg   <= col_next;
            root_reg  <= root_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        term_next  = term_reg;
        col_next   = col_reg;
        root_next  = root_reg;
        unique case (state_reg)
            cs3_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = cs3_pkg::ST_TERM_LOAD;
                    term_next  = '0;
                    col_next   = cs3_pkg::COL_MAIN;
                    root_next  = '0;
                end
            end
            cs3_pkg::ST_TERM_LOAD: state_next = cs3_pkg::ST_MUL1;
            cs3_pkg::ST_MUL1:      state_next = cs3_pkg::ST_MUL2;
            cs3_pkg::ST_MUL2:      state_next = cs3_pkg::ST_MUL3;
            cs3_pkg::ST_MUL3:      state_next = cs3_pkg::ST_ACCUM;
            cs3_pkg::ST_ACCUM:
            begin
                if (term_reg == 3'd5)
                    state_next = cs3_pkg::ST_DET_DONE;
                else
                begin
                    term_next  = term_reg + 3'd1;
                    state_next = cs3_pkg::ST_TERM_LOAD;
                end
            end
            cs3_pkg::ST_DET_DONE:
            begin
                term_next = '0;
                if (col_reg == cs3_pkg::COL_MAIN)
                begin
                    if (sts.det_zero)
                        state_next = cs3_pkg::ST_EMIT;
                    else
                    begin
                        col_next   = 2'd0;
                        state_next = cs3_pkg::ST_TERM_LOAD;
                    end
                end
                else
                    state_next = cs3_pkg::ST_DIV;
            end
            cs3_pkg::ST_DIV:
                if (sts.div_done)
                    state_next = cs3_pkg::ST_EMIT;
            cs3_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    root_next = root_reg + 2'd1;
                    if (root_reg == 2'd2)
                        state_next = cs3_pkg::ST_IDLE;
                    else if (sts.main_zero)
                        state_next = cs3_pkg::ST_EMIT;
                    else
                    begin
                        col_next   = col_reg + 2'd1;
                        state_next = cs3_pkg::ST_TERM_LOAD;
                    end
                end
            end
            default: state_next = cs3_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.term      = term_reg;
        cmd.col       = col_reg;
        cmd.term_load = (state_reg == cs3_pkg::ST_TERM_LOAD);
        cmd.mul1      = (state_reg == cs3_pkg::ST_MUL1);
        cmd.mul2      = (state_reg == cs3_pkg::ST_MUL2);
        cmd.mul3      = (state_reg == cs3_pkg::ST_MUL3);
        cmd.accum     = (state_reg == cs3_pkg::ST_ACCUM);
        cmd.det_done  = (state_reg == cs3_pkg::ST_DET_DONE);
        cmd.div_start = (state_reg == cs3_pkg::ST_DET_DONE) && (col_reg != cs3_pkg::COL_MAIN);
        cmd.div_step  = (state_reg == cs3_pkg::ST_DIV);
        cmd.emit      = (state_reg == cs3_pkg::ST_EMIT) && out_free;
        busy          = (state_reg != cs3_pkg::ST_IDLE);
        root_num      = root_reg;
    end

endmodule

// File: hw/rtl/cs3_dp.sv
`timescale 1ns / 1ps

module cs3_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  wr_en,
    input  logic [cs3_pkg::IDX_W-1:0]             wr_idx,
    input  logic signed [cs3_pkg::DATA_WIDTH-1:0] wr_data,
    input  cs3_pkg::cs3_cmd_t                     cmd,
    output cs3_pkg::cs3_sts_t                     sts,
    output logic signed [cs3_pkg::DATA_WIDTH-1:0] root,
    output logic                                  sat,
    output logic                                  sing
);

    localparam int DW  = cs3_pkg::DATA_WIDTH;
    localparam int PW  = cs3_pkg::PROD_W;
    localparam int DTW = cs3_pkg::DET_W;
    localparam int NW  = cs3_pkg::NUM_W;
    localparam int QW  = cs3_pkg::QCNT_W;

    logic [DW-1:0] store_reg [cs3_pkg::STORE_DEPTH];

    logic [DW-1:0]  a_mag_reg, b_mag_reg, c_mag_reg;
    logic           neg_reg;
    logic [2*DW-1:0] p1_reg;
    logic [PW-1:0]  p2_reg;
    logic signed [DTW-1:0] det_reg, dmain_reg;
    logic           zero_reg;

    logic [NW-1:0]  num_reg, den_reg, rem_reg, quo_reg;
    logic [QW-1:0]  cnt_reg;
    logic           qneg_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_idx < 4'(cs3_pkg::STORE_DEPTH)))
            store_reg[wr_idx] <= wr_data;
    end

    // fetch with column replacement by right-hand side
    function automatic logic [cs3_pkg::IDX_W-1:0] src(input logic [cs3_pkg::IDX_W-1:0] p,
                                                      input logic [1:0] col);
        logic [cs3_pkg::IDX_W-1:0] r;
        logic [1:0] c;
        r = p;
        c = (p == 4'd0 || p == 4'd3 || p == 4'd6) ? 2'd0 :
            (p == 4'd1 || p == 4'd4 || p == 4'd7) ? 2'd1 : 2'd2;
        if (col == c)
            r = (p < 4'd3) ? 4'd9 : (p < 4'd6) ? 4'd10 : 4'd11;
        return r;
    endfunction

    logic [DW-1:0] ea, eb, ec;
    assign ea = store_reg[src(cs3_pkg::term_pos(cmd.term, 2'd0), cmd.col)];
    assign eb = store_reg[src(cs3_pkg::term_pos(cmd.term, 2'd1), cmd.col)];
    assign ec = store_reg[src(cs3_pkg::term_pos(cmd.term, 2'd2), cmd.col)];

    function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
        return v[DW-1] ? (~v + 1'b1) : v;
    endfunction

    // second product: low half of p1 times c in MUL2, then high half in MUL3
    logic [DW-1:0]   mul_a;
    logic [2*DW-1:0] mul_p;
    assign mul_a = cmd.mul3 ? p1_reg[2*DW-1:DW] : p1_reg[DW-1:0];
    assign mul_p = mul_a * c_mag_reg;

    logic [NW-1:0] rem_sh;
    logic          ge;
    assign rem_sh = {rem_reg[NW-2:0], num_reg[NW-1]};
    assign ge     = (rem_sh >= den_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.div_start)
            cnt_reg <= QW'(NW);
        else if (cmd.div_step && cnt_reg != '0)
            cnt_reg <= cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.term_load)
        begin
            a_mag_reg <= mag(ea);
            b_mag_reg <= mag(eb);
            c_mag_reg <= mag(ec);
            neg_reg   <= ea[DW-1] ^ eb[DW-1] ^ ec[DW-1] ^ (cmd.term >= 3'd3);
        end
        if (cmd.mul1)
            p1_reg <= a_mag_reg * b_mag_reg;
        if (cmd.mul2)
            p2_reg <= PW'(mul_p);
        if (cmd.mul3)
            p2_reg <= p2_reg + {mul_p, {DW{1'b0}}};
        if (cmd.accum)
            det_reg <= (cmd.term == 3'd0 ? DTW'(0) : det_reg)
                       + (neg_reg ? -$signed({4'd0, p2_reg}) : $signed({4'd0, p2_reg}));
        if (cmd.det_done && cmd.col == cs3_pkg::COL_MAIN)
        begin
            dmain_reg <= det_reg;
            zero_reg  <= (det_reg == '0);
        end
        if (cmd.div_start)
        begin
            num_reg  <= det_reg[DTW-1] ? NW'(-(det_reg)) << cs3_pkg::FRAC_BITS
                                       : NW'(det_reg) << cs3_pkg::FRAC_BITS;
            den_reg  <= dmain_reg[DTW-1] ? NW'(-dmain_reg) : NW'(dmain_reg);
            qneg_reg <= det_reg[DTW-1] ^ dmain_reg[DTW-1];
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (cmd.div_step && cnt_reg != '0)
        begin
            num_reg <= {num_reg[NW-2:0], 1'b0};
            rem_reg <= ge ? rem_sh - den_reg : rem_sh;
            quo_reg <= {quo_reg[NW-2:0], ge};
        end
    end

    assign sts.det_zero  = (det_reg == '0);
    assign sts.main_zero = zero_reg;
    assign sts.div_done  = cmd.div_step && (cnt_reg == '0);

    // saturation of the quotient magnitude
    localparam logic [NW-1:0] LIM = NW'(1) << (DW - 1);
    always_comb
    begin
        sing = zero_reg;
        sat  = 1'b0;
        root = '0;
        if (!zero_reg)
        begin
            if (qneg_reg)
            begin
                if (quo_reg > LIM)
                begin
                    sat  = 1'b1;
                    root = DW'(-LIM);
                end
                else
                    root = DW'(-quo_reg);
            end
            else
            begin
                if (quo_reg > LIM - 1'b1)
                begin
                    sat  = 1'b1;
                    root = DW'(LIM - 1'b1);
                end
                else
                    root = DW'(quo_reg);
            end
        end
    end

endmodule

// File: hw/rtl/cramer_solver_3x3_core.sv
`timescale 1ns / 1ps
// sequence: each determinant runs its six terms through TERM_LOAD, MUL1, MUL2, MUL3 and
//   ACCUM, then DET_DONE closes it; each root then takes a restoring divide, one quotient
//   bit per DIV step; a singular system emits its roots straight after the main determinant
// throughput: loads take one beat per cycle while idle; a solve blocks input until its
//   third root is registered, later if the output stalls; solve time is set by the
//   sequential multiply steps and the bit-serial divider
// reset: rst_n asynchronous active low clears control; coefficient store is not reset
module cramer_solver_3x3_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [cs3_pkg::IDX_W-1:0]             element_index,
    input  logic signed [cs3_pkg::DATA_WIDTH-1:0] element_value,
    input  logic                                  last_element,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [1:0]                            root_index,
    output logic signed [cs3_pkg::DATA_WIDTH-1:0] root_value,
    output logic                                  singular,
    output logic                                  saturated,
    output logic                                  last_root
);

    cs3_pkg::cs3_cmd_t cmd;
    cs3_pkg::cs3_sts_t sts;
    logic       busy, accept, out_free;
    logic [1:0] root_num;
    logic signed [cs3_pkg::DATA_WIDTH-1:0] root;
    logic       sat, sing;

    logic       ovalid_reg;
    logic [1:0] oidx_reg;
    logic signed [cs3_pkg::DATA_WIDTH-1:0] oval_reg;
    logic       osing_reg, osat_reg, olast_reg;

    // beats are stored while no solve is running
    assign in_ready = !busy;
    assign accept   = in_valid && in_ready;
    // output register frees when empty or being drained
    assign out_free = !ovalid_reg || out_ready;

    cs3_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && last_element),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy),
        .root_num (root_num)
    );

    cs3_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_idx  (element_index),
        .wr_data (element_value),
        .cmd     (cmd),
        .sts     (sts),
        .root    (root),
        .sat     (sat),
        .sing    (sing)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (cmd.emit)
            ovalid_reg <= 1'b1;
        else if (out_ready)
            ovalid_reg <= 1'b0;
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            oidx_reg  <= root_num;
            oval_reg  <= root;
            osing_reg <= sing;
            osat_reg  <= sat;
            olast_reg <= (root_num == 2'd2);
        end
    end

    assign out_valid  = ovalid_reg;
    assign root_index = oidx_reg;
    assign root_value = oval_reg;
    assign singular   = osing_reg;
    assign saturated  = osat_reg;
    assign last_root  = olast_reg;

endmodule

// File: hw/rtl/cs3_checker.sv
`timescale 1ns / 1ps

module cs3_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] root_index,
    input logic       singular,
    input logic       saturated,
    input logic       last_root
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(root_index))
        else $error("result beat dropped while stalled");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_root == (root_index == 2'd2)))
        else $error("last_root mismatch");

    a_sing_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> !saturated)
        else $error("singular root flagged saturated");

    a_no_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && root_index != 2'd2 |-> !in_ready)
        else $error("input taken mid solve");

endmodule

bind cramer_solver_3x3_core cs3_checker u_cs3_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .root_index (root_index),
    .singular   (singular),
    .saturated  (saturated),
    .last_root  (last_root)
);

// File: sim/cramer_solver_3x3_core_tb.sv
`timescale 1ns / 1ps

module cramer_solver_3x3_core_tb;

    localparam int  NUM_ITEMS   = 250;
    localparam int  DRAIN_WAIT  = 800;
    localparam longint CYCLE_LIMIT = 4000000;

    // exact determinant arithmetic, wide enough for shifted triple-product sums
    typedef logic signed [191:0] det_t;

    typedef struct {
        logic [cs3_pkg::IDX_W-1:0]      idx;
        logic [cs3_pkg::DATA_WIDTH-1:0] val;
        logic                           last;
    } coef_beat_t;

    typedef struct {
        logic [1:0]                     idx;
        logic [cs3_pkg::DATA_WIDTH-1:0] val;
        logic                           sing;
        logic                           sat;
        logic                           last;
    } root_beat_t;

    logic                                  clk;
    logic                                  rst_n;
    logic                                  in_valid;
    logic                                  in_ready;
    logic [cs3_pkg::IDX_W-1:0]             element_index;
    logic signed [cs3_pkg::DATA_WIDTH-1:0] element_value;
    logic                                  last_element;
    logic                                  out_valid;
    logic                                  out_ready;
    logic [1:0]                            root_index;
    logic signed [cs3_pkg::DATA_WIDTH-1:0] root_value;
    logic                                  singular;
    logic                                  saturated;
    logic                                  last_root;

    coef_beat_t pending_coefs[$];
    root_beat_t expected_roots[$];
    logic [cs3_pkg::DATA_WIDTH-1:0] coef_model[cs3_pkg::STORE_DEPTH];

    int     mismatches;
    bit     failed;
    longint cycle_count;
    bit     in_fire;
    bit     out_fire;
    int     in_gap;
    int     out_stall;
    bit     in_burst;
    bit     out_burst;
    int     item_count;

    cramer_solver_3x3_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .element_index (element_index),
        .element_value (element_value),
        .last_element  (last_element),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .root_index    (root_index),
        .root_value    (root_value),
        .singular      (singular),
        .saturated     (saturated),
        .last_root     (last_root)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic det_t triple(input logic [9*cs3_pkg::DATA_WIDTH-1:0] m,
                                    input int i, input int j, input int k);
        det_t a;
        det_t b;
        det_t c;
        a = $signed(m[i*cs3_pkg::DATA_WIDTH +: cs3_pkg::DATA_WIDTH]);
        b = $signed(m[j*cs3_pkg::DATA_WIDTH +: cs3_pkg::DATA_WIDTH]);
        c = $signed(m[k*cs3_pkg::DATA_WIDTH +: cs3_pkg::DATA_WIDTH]);
        return a * b * c;
    endfunction

    function automatic det_t det3x3(input logic [9*cs3_pkg::DATA_WIDTH-1:0] m);
        return triple(m, 0, 4, 8) + triple(m, 1, 5, 6) + triple(m, 3, 7, 2)
             - triple(m, 2, 4, 6) - triple(m, 0, 5, 7) - triple(m, 1, 3, 8);
    endfunction

    // solve the stored system and queue the three roots it should produce
    task automatic predict_roots();
        logic [9*cs3_pkg::DATA_WIDTH-1:0] a_mat;
        logic [9*cs3_pkg::DATA_WIDTH-1:0] k_mat;
        det_t       d_main;
        det_t       quot;
        det_t       hi_lim;
        det_t       lo_lim;
        root_beat_t r;
        hi_lim = (det_t'(1) <<< (cs3_pkg::DATA_WIDTH - 1)) - 1;
        lo_lim = -(det_t'(1) <<< (cs3_pkg::DATA_WIDTH - 1));
        for (int p = 0; p < 9; p++)
            a_mat[p*cs3_pkg::DATA_WIDTH +: cs3_pkg::DATA_WIDTH] = coef_model[p];
        d_main = det3x3(a_mat);
        for (int z = 0; z < 3; z++)
        begin
            r.idx  = 2'(z);
            r.last = (z == 2);
            r.sing = (d_main == 0);
            r.sat  = 1'b0;
            r.val  = '0;
            if (d_main != 0)
            begin
                k_mat = a_mat;
                for (int row = 0; row < 3; row++)
                    k_mat[(row*3+z)*cs3_pkg::DATA_WIDTH +: cs3_pkg::DATA_WIDTH] =
                        coef_model[9+row];
                // signed division truncates toward zero
                quot = (det3x3(k_mat) <<< cs3_pkg::FRAC_BITS) / d_main;
                if (quot > hi_lim)
                begin
                    quot  = hi_lim;
                    r.sat = 1'b1;
                end
                else if (quot < lo_lim)
                begin
                    quot  = lo_lim;
                    r.sat = 1'b1;
                end
                r.val = quot[cs3_pkg::DATA_WIDTH-1:0];
            end
            expected_roots.push_back(r);
        end
    endtask

    task automatic queue_coef(input int idx, input logic [31:0] val, input bit last);
        coef_beat_t c;
        c.idx  = cs3_pkg::IDX_W'(idx);
        c.val  = val;
        c.last = last;
        pending_coefs.push_back(c);
        item_count++;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0, 1:    return $urandom;
            2:       return 32'($urandom_range(0, 32'h3ffff)) - 32'h20000;
            3:       return (32'($urandom_range(0, 16)) - 32'd8) << cs3_pkg::FRAC_BITS;
            4:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return $urandom_range(0, 3) - 1;
        endcase
    endfunction

    // full system written in shuffled order, solve on the final beat
    task automatic queue_system();
        int order[12];
        int j;
        int t;
        for (int i = 0; i < 12; i++)
            order[i] = i;
        for (int i = 11; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < 12; i++)
            queue_coef(order[i], pick_value(), i == 11);
    endtask

    // driver: present coefficient beats at the falling edge
    always @(negedge clk)
    begin
        if (!rst_n || (in_valid && !in_fire))
        begin
            // hold the current beat
        end
        else if (in_gap > 0)
        begin
            in_gap--;
            in_valid <= 1'b0;
        end
        else if (pending_coefs.size() > 0)
        begin
            coef_beat_t c;
            c = pending_coefs.pop_front();
            element_index <= c.idx;
            element_value <= c.val;
            last_element  <= c.last;
            in_valid      <= 1'b1;
            if ($urandom_range(0, 7) == 0)
                in_burst = !in_burst;
            in_gap = in_burst ? 0 : $urandom_range(0, 11);
        end
        else
            in_valid <= 1'b0;
    end

    // receiver backpressure, one stall draw per root
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_fire)
            begin
                if ($urandom_range(0, 7) == 0)
                    out_burst = !out_burst;
                out_stall = out_burst ? 0 : $urandom_range(0, 11);
            end
            if (out_stall > 0)
            begin
                out_stall--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // monitor: model accepted coefficients and check roots at the rising edge
    always @(posedge clk)
    begin
        in_fire  = rst_n && in_valid && in_ready;
        out_fire = rst_n && out_valid && out_ready;
        cycle_count++;
        if (in_fire)
        begin
            if (element_index < cs3_pkg::STORE_DEPTH)
                coef_model[element_index] = element_value;
            if (last_element)
                predict_roots();
        end
        if (out_fire)
        begin
            if (expected_roots.size() == 0)
            begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected root beat: idx %0d value %h",
                             root_index, root_value);
            end
            else
            begin
                root_beat_t e;
                e = expected_roots.pop_front();
                if (root_index !== e.idx || root_value !== e.val || singular !== e.sing
                    || saturated !== e.sat || last_root !== e.last)
                begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"root mismatch: exp idx %0d val %h sing %b sat %b ",
                                  "last %b, got idx %0d val %h sing %b sat %b last %b"},
                                 e.idx, e.val, e.sing, e.sat, e.last, root_index,
                                 root_value, singular, saturated, last_root);
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL cramer_solver_3x3_core");
            $finish;
        end
    end

    initial
    begin
        int kind;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        out_ready     = 1'b0;
        element_index = '0;
        element_value = '0;
        last_element  = 1'b0;
        mismatches    = 0;
        failed        = 1'b0;
        cycle_count   = 0;
        in_gap        = 0;
        out_stall     = 0;
        in_burst      = 1'b0;
        out_burst     = 1'b0;
        item_count    = 0;
        for (int i = 0; i < cs3_pkg::STORE_DEPTH; i++)
            coef_model[i] = '0;

        // identity matrix with b = 1, 2, -3
        for (int i = 0; i < 9; i++)
            queue_coef(i, (i % 4 == 0) ? 32'h00010000 : 32'h0, 1'b0);
        queue_coef(9, 32'h00010000, 1'b0);
        queue_coef(10, 32'h00020000, 1'b0);
        queue_coef(11, 32'hfffd0000, 1'b1);
        // zero on the diagonal makes the matrix singular
        queue_coef(0, 32'h0, 1'b1);
        // tiny pivot with large b overflows upward, then downward
        queue_coef(0, 32'h1, 1'b0);
        queue_coef(9, 32'h7fffffff, 1'b1);
        queue_coef(9, 32'h80000000, 1'b1);
        // out-of-range indexes: discarded, but a last beat still solves
        queue_coef(12, 32'h12345678, 1'b0);
        queue_coef(13, 32'hffffffff, 1'b0);
        queue_coef(14, 32'h0, 1'b0);
        queue_coef(15, 32'hdeadbeef, 1'b1);
        // extreme coefficients
        queue_coef(4, 32'h80000000, 1'b0);
        queue_coef(8, 32'h7fffffff, 1'b0);
        queue_coef(1, 32'hffffffff, 1'b0);
        queue_coef(0, 32'h80000000, 1'b1);

        while (item_count < NUM_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 6)
                queue_system();
            else if (kind == 7)
                queue_coef($urandom_range(0, 11), pick_value(), 1'b1);
            else if (kind == 8)
                queue_coef($urandom_range(12, 15), $urandom, $urandom_range(0, 1));
            else
                for (int i = $urandom_range(1, 4); i > 0; i--)
                    queue_coef($urandom_range(0, 11), pick_value(), 1'b0);
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_coefs.size() == 0 && !in_valid && expected_roots.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (expected_roots.size() != 0)
            failed = 1'b1;

        if (!failed)
            $display("PASS cramer_solver_3x3_core");
        else
            $display("FAIL cramer_solver_3x3_core");
        $finish;
    end

endmodule
